/* src/rtgm_pkg.sv */
`default_nettype none
package rtgm_pkg;

  localparam int CAPACITY_DEF = 64;

  // request kinds
  localparam logic [1:0] REQ_APPEND  = 2'd0;
  localparam logic [1:0] REQ_SEARCH  = 2'd1;
  localparam logic [1:0] REQ_DELETE  = 2'd2;
  localparam logic [1:0] REQ_EXTRACT = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_BADINDEX = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [11:0] year;
    logic [6:0]  age_min;
    logic [6:0]  age_max;
    logic [19:0] admitted;
    logic [14:0] rate;
  } rec_t;

  // candidate beats current best: more admitted, then higher rate
  function automatic logic better(input rec_t c, input rec_t b);
    logic res;
    if (c.admitted != b.admitted) res = c.admitted > b.admitted;
    else res = c.rate > b.rate;
    return res;
  endfunction

endpackage
`default_nettype wire

/* src/record_table_group_max.sv */
// channel | handshake            | payload
// in      | in_valid, in_stall   | req_type, year, age_min, age_max, admitted,
//         |                      | success_rate, index
// out     | out_valid, out_stall | status, found_index, year_res, age_min_res,
//         |                      | age_max_res, admitted_res, success_rate_res, last
//
// One request at a time; search and delete scan one entry a cycle through the one memory.
// Extract makes two passes per distinct year plus a final pass, bound by the one memory
// read port.
// Reset empties the table by clearing the count and holds the input stalled; no clearing pass.
// A stalled output holds the request in progress until the result is taken.
`default_nettype none
module record_table_group_max
  import rtgm_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [11:0] year,
  input  wire logic [6:0]  age_min,
  input  wire logic [6:0]  age_max,
  input  wire logic [19:0] admitted,
  input  wire logic [14:0] success_rate,
  input  wire logic [5:0]  index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [5:0]       found_index,
  output logic [11:0]      year_res,
  output logic [6:0]       age_min_res,
  output logic [6:0]       age_max_res,
  output logic [19:0]      admitted_res,
  output logic [14:0]      success_rate_res,
  output logic             last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_XA   = 3'd3;
  localparam logic [2:0] S_XB   = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]    state;
  logic [2:0]    ret;
  logic [CW-1:0] count;
  logic [CW-1:0] rd_i;
  logic          dv;
  logic [AW-1:0] di;
  logic          fnd;
  logic [AW-1:0] fidx;
  logic [11:0]   key;
  logic [11:0]   prev;
  logic          have_prev;
  logic          have_pend;
  rec_t          pend;
  rec_t          best;

  // staged result waiting for the output register
  logic [2:0]    res_status;
  logic [5:0]    res_fidx;
  rec_t          res_rec;
  logic          res_last;

  // record memory
  rec_t          mem [CAPACITY];
  rec_t          rdata;
  logic          we;
  logic [AW-1:0] wa;
  rec_t          wd;
  logic [AW-1:0] ra;

  logic          in_acc;
  logic          out_free;
  logic          issue;
  logic          done;
  logic [CW+5:0] fidx_wide;
  logic [IW-1:0] idx_ext;
  logic [IW-1:0] cnt_ext;
  rec_t          in_rec;

  assign in_stall  = rst || (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign issue     = (rd_i < count);
  assign done      = !issue && !dv;
  assign ra        = rd_i[AW-1:0];
  assign fidx_wide = (CW + 6)'(fidx);
  assign idx_ext   = IW'(index);
  assign cnt_ext   = IW'(count);
  assign in_rec    = '{year: year, age_min: age_min, age_max: age_max,
                       admitted: admitted, rate: success_rate};

  // memory write port: append or delete shift
  always_comb begin
    we = 1'b0;
    wa = count[AW-1:0];
    wd = in_rec;
    if (state == S_IDLE) begin
      we = in_acc && (req_type == REQ_APPEND) && (count < CW'(CAPACITY));
    end else if (state == S_DEL) begin
      we = dv;
      wa = di - AW'(1);
      wd = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra];
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      count     <= '0;
      rd_i      <= '0;
      dv        <= 1'b0;
      fnd       <= 1'b0;
      have_prev <= 1'b0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;

      // shared scan pipeline
      if (state == S_SRCH || state == S_DEL || state == S_XA || state == S_XB) begin
        dv <= issue;
        di <= ra;
        if (issue) rd_i <= rd_i + CW'(1);
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            res_status <= ST_OK;
            res_fidx   <= '0;
            res_rec    <= '0;
            res_last   <= 1'b1;
            ret        <= S_IDLE;
            dv         <= 1'b0;
            fnd        <= 1'b0;
            case (req_type)
              REQ_APPEND: begin
                if (count < CW'(CAPACITY)) count <= count + CW'(1);
                else res_status <= ST_FULL;
                state <= S_EMIT;
              end
              REQ_SEARCH: begin
                key   <= year;
                rd_i  <= '0;
                state <= S_SRCH;
              end
              REQ_DELETE: begin
                if (idx_ext >= cnt_ext) begin
                  res_status <= ST_BADINDEX;
                  state      <= S_EMIT;
                end else begin
                  rd_i  <= CW'(index) + CW'(1);
                  state <= S_DEL;
                end
              end
              default: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  have_prev <= 1'b0;
                  have_pend <= 1'b0;
                  rd_i      <= '0;
                  state     <= S_XA;
                end
              end
            endcase
          end
        end

        S_SRCH: begin
          if (dv && !fnd && rdata.year == key) begin
            fnd  <= 1'b1;
            fidx <= di;
          end
          if (done) begin
            res_status <= fnd ? ST_OK : ST_NOTFOUND;
            res_fidx   <= fnd ? fidx_wide[5:0] : 6'd0;
            state      <= S_EMIT;
          end
        end

        S_DEL: begin
          if (done) begin
            count <= count - CW'(1);
            state <= S_EMIT;
          end
        end

        // smallest year above the previous one
        S_XA: begin
          if (dv && (!have_prev || rdata.year > prev) && (!fnd || rdata.year < key)) begin
            key <= rdata.year;
            fnd <= 1'b1;
          end
          if (done) begin
            res_status <= ST_OK;
            res_fidx   <= '0;
            res_rec    <= pend;
            if (!fnd) begin
              res_last <= 1'b1;
              ret      <= S_IDLE;
              state    <= S_EMIT;
            end else begin
              rd_i <= '0;
              fnd  <= 1'b0;
              if (have_pend) begin
                res_last <= 1'b0;
                ret      <= S_XB;
                state    <= S_EMIT;
              end else begin
                state <= S_XB;
              end
            end
          end
        end

        // best record of the chosen year
        S_XB: begin
          if (dv && rdata.year == key && (!fnd || better(rdata, best))) begin
            best <= rdata;
            fnd  <= 1'b1;
          end
          if (done) begin
            pend      <= best;
            have_pend <= 1'b1;
            prev      <= key;
            have_prev <= 1'b1;
            fnd       <= 1'b0;
            rd_i      <= '0;
            state     <= S_XA;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            status           <= res_status;
            found_index      <= res_fidx;
            year_res         <= res_rec.year;
            age_min_res      <= res_rec.age_min;
            age_max_res      <= res_rec.age_max;
            admitted_res     <= res_rec.admitted;
            success_rate_res <= res_rec.rate;
            last             <= res_last;
            dv               <= 1'b0;
            state            <= ret;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* tb/record_table_group_max_tb.sv */
`timescale 1ns / 1ps
module record_table_group_max_tb;
  import rtgm_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int IDLE_LIMIT = 40000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [11:0] year;
  logic [6:0]  age_min;
  logic [6:0]  age_max;
  logic [19:0] admitted;
  logic [14:0] success_rate;
  logic [5:0]  index;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [5:0]  found_index;
  logic [11:0] year_res;
  logic [6:0]  age_min_res;
  logic [6:0]  age_max_res;
  logic [19:0] admitted_res;
  logic [14:0] success_rate_res;
  logic        last;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  fidx;
    rec_t        rec;
    logic        last;
  } answer_t;

  typedef struct {
    logic [1:0]  req;
    rec_t        rec;
    logic [5:0]  idx;
    logic        has_ans;
    answer_t     ans;
  } row_t;

  record_table_group_max uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .year(year), .age_min(age_min), .age_max(age_max),
    .admitted(admitted), .success_rate(success_rate), .index(index),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .found_index(found_index), .year_res(year_res), .age_min_res(age_min_res),
    .age_max_res(age_max_res), .admitted_res(admitted_res),
    .success_rate_res(success_rate_res), .last(last)
  );

  // shadow table
  rec_t    tbl[CAP];
  int      tbl_n;
  answer_t pending_answers[$];
  int      errors;
  int      idle_cycles;
  bit      sending_done;
  bit      quiet_mode;
  bit      hold_off;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic answer_t mk(logic [2:0] st, logic [5:0] fi, rec_t r, logic l);
    answer_t a;
    a.status = st; a.fidx = fi; a.rec = r; a.last = l;
    return a;
  endfunction

  // predict results of one transaction and update shadow table
  task automatic table_apply(input logic [1:0] req, input rec_t r, input logic [5:0] idx);
    rec_t zero;
    bit found;
    bit have_prev;
    logic [11:0] prev;
    logic [11:0] yr;
    int best;
    zero = '0;
    case (req)
      REQ_APPEND: begin
        if (tbl_n >= CAP) pending_answers.push_back(mk(ST_FULL, 0, zero, 1));
        else begin
          tbl[tbl_n] = r; tbl_n++;
          pending_answers.push_back(mk(ST_OK, 0, zero, 1));
        end
      end
      REQ_SEARCH: begin
        found = 0;
        for (int i = 0; i < tbl_n && !found; i++)
          if (tbl[i].year == r.year) begin
            found = 1;
            pending_answers.push_back(mk(ST_OK, i[5:0], zero, 1));
          end
        if (!found) pending_answers.push_back(mk(ST_NOTFOUND, 0, zero, 1));
      end
      REQ_DELETE: begin
        if (idx >= tbl_n) pending_answers.push_back(mk(ST_BADINDEX, 0, zero, 1));
        else begin
          for (int i = idx; i + 1 < tbl_n; i++) tbl[i] = tbl[i + 1];
          tbl_n--;
          pending_answers.push_back(mk(ST_OK, 0, zero, 1));
        end
      end
      default: begin
        if (tbl_n == 0) pending_answers.push_back(mk(ST_EMPTY, 0, zero, 1));
        else begin
          have_prev = 0; prev = 0;
          forever begin
            found = 0; yr = 0;
            for (int i = 0; i < tbl_n; i++)
              if (!(have_prev && tbl[i].year <= prev) && (!found || tbl[i].year < yr)) begin
                yr = tbl[i].year; found = 1;
              end
            if (!found) break;
            best = -1;
            for (int i = 0; i < tbl_n; i++)
              if (tbl[i].year == yr) begin
                if (best < 0) best = i;
                else if (tbl[i].admitted != tbl[best].admitted) begin
                  if (tbl[i].admitted > tbl[best].admitted) best = i;
                end else if (tbl[i].rate > tbl[best].rate) best = i;
              end
            pending_answers.push_back(mk(ST_OK, 0, tbl[best], 0));
            prev = yr; have_prev = 1;
          end
          pending_answers[pending_answers.size() - 1].last = 1'b1;
        end
      end
    endcase
  endtask

  // send one transaction, wait for acceptance
  task automatic send_request(input logic [1:0] req, input rec_t r, input logic [5:0] idx);
    while (!quiet_mode && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req; year <= r.year; age_min <= r.age_min; age_max <= r.age_max;
    admitted <= r.admitted; success_rate <= r.rate; index <= idx;
    table_apply(req, r, idx);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random record, small year range unless wide, so groups form
  function automatic rec_t rand_rec(bit wide);
    rec_t r;
    r.year = wide ? 12'($urandom) : 12'(2000 + $urandom_range(7));
    r.age_min = 7'($urandom);
    r.age_max = 7'($urandom);
    r.admitted = ($urandom_range(3) == 0) ? 20'($urandom_range(3)) : 20'($urandom);
    r.rate = ($urandom_range(3) == 0) ? 15'($urandom_range(1)) : 15'($urandom);
    return r;
  endfunction

  // receiver stall generation
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_off || (!quiet_mode && $urandom_range(99) < 21);
  end

  // result checking
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && out_valid && !out_stall) begin
      got = mk(status, found_index,
               {year_res, age_min_res, age_max_res, admitted_res, success_rate_res}, last);
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d fi=%0d rec=%h last=%b got st=%0d fi=%0d rec=%h last=%b",
                     want.status, want.fidx, want.rec, want.last,
                     got.status, got.fidx, got.rec, got.last);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // long receiver hold-off while sender keeps going
  initial begin
    hold_off = 1'b0;
    wait (sending_done == 1'b0 && !rst);
    repeat (600) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  row_t directed[$];

  task automatic add_row(logic [1:0] q, rec_t r, logic [5:0] i);
    row_t w;
    w.req = q; w.rec = r; w.idx = i; w.has_ans = 0; w.ans = '0;
    directed.push_back(w);
  endtask

  task automatic add_fixed(logic [1:0] q, rec_t r, logic [5:0] i, answer_t a);
    row_t w;
    w.req = q; w.rec = r; w.idx = i; w.has_ans = 1; w.ans = a;
    directed.push_back(w);
  endtask

  initial begin
    rec_t z;
    rec_t hi;
    int depth;
    z = '0;
    hi = '1;
    errors = 0; tbl_n = 0; sending_done = 0; quiet_mode = 0;
    rst = 1'b1; in_valid = 1'b0; req_type = REQ_APPEND; year = 0; age_min = 0;
    age_max = 0; admitted = 0; success_rate = 0; index = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table: empty-table cases first
    add_fixed(REQ_EXTRACT, z, 0, mk(ST_EMPTY, 0, z, 1));
    add_fixed(REQ_SEARCH, hi, 0, mk(ST_NOTFOUND, 0, z, 1));
    add_fixed(REQ_DELETE, z, 0, mk(ST_BADINDEX, 0, z, 1));
    add_fixed(REQ_APPEND, hi, 0, mk(ST_OK, 0, z, 1));
    add_fixed(REQ_APPEND, z, 0, mk(ST_OK, 0, z, 1));
    add_row(REQ_APPEND, '{12'd5, 7'd90, 7'd10, 20'd100, 15'd300}, 0);
    add_row(REQ_APPEND, '{12'd5, 7'd1, 7'd2, 20'd100, 15'd400}, 0);
    add_row(REQ_APPEND, '{12'd5, 7'd3, 7'd4, 20'd100, 15'd400}, 0);
    add_row(REQ_APPEND, '{12'd0, 7'd3, 7'd4, 20'd7, 15'd25600}, 0);
    add_row(REQ_SEARCH, '{12'd5, 0, 0, 0, 0}, 0);
    add_row(REQ_SEARCH, '{12'd0, 0, 0, 0, 0}, 0);
    add_row(REQ_EXTRACT, z, 0);
    add_fixed(REQ_DELETE, z, 63, mk(ST_BADINDEX, 0, z, 1));
    add_row(REQ_DELETE, z, 0);
    add_row(REQ_EXTRACT, z, 0);
    add_row(REQ_SEARCH, hi, 0);

    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].rec, directed[i].idx);
      if (directed[i].has_ans &&
          pending_answers[pending_answers.size() - 1] !== directed[i].ans) begin
        errors++;
        if (errors <= 10) $display("directed row %0d disagrees with table", i);
      end
    end

    // fill to capacity and overflow, then trim by deletes
    while (tbl_n < CAP) send_request(REQ_APPEND, rand_rec($urandom_range(1)), 0);
    send_request(REQ_APPEND, rand_rec(0), 0);
    send_request(REQ_SEARCH, rand_rec(0), 0);
    send_request(REQ_EXTRACT, z, 0);
    send_request(REQ_DELETE, z, 63);
    while (tbl_n > 52) send_request(REQ_DELETE, z, 6'($urandom_range(tbl_n - 1)));

    // random traffic with one quiet stretch
    for (int n = 0; n < 30; n++) begin
      quiet_mode = (n >= 10 && n < 25);
      case ($urandom_range(9))
        0, 1, 2, 3: send_request(REQ_APPEND, rand_rec($urandom_range(7) == 0), 6'($urandom));
        4, 5: send_request(REQ_SEARCH, rand_rec($urandom_range(3) == 0), 6'($urandom));
        6, 7: begin
          depth = (tbl_n > 0 && $urandom_range(4) != 0) ? $urandom_range(tbl_n - 1)
                                                        : $urandom_range(63);
          send_request(REQ_DELETE, rand_rec(1), 6'(depth));
        end
        default: send_request(REQ_EXTRACT, rand_rec(1), 6'($urandom));
      endcase
    end
    in_valid <= 1'b0;
    quiet_mode = 0;
    sending_done = 1;

    wait (pending_answers.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
